>>> rtl/lspg_pkg.sv
package lspg_pkg;

    // image and scan geometry
    localparam int unsigned LSPG_IMAGE_SIDE = 120;
    localparam int unsigned LSPG_MAX_BEAMS  = 4096;

    // field and register widths
    localparam int unsigned LSPG_RANGE_W    = 16;
    localparam int unsigned LSPG_BEAM_W     = 12;
    localparam int unsigned LSPG_PIXEL_W    = 7;
    localparam int unsigned LSPG_START_W    = 16;
    localparam int unsigned LSPG_STEP_W     = 20;
    localparam int unsigned LSPG_SCALE_W    = 16;
    localparam int unsigned LSPG_CFG_DATA_W = 20;
    localparam int unsigned LSPG_CFG_IDX_W  = 2;

    // register map
    typedef enum logic [LSPG_CFG_IDX_W-1:0] {
        REG_ANGLE_START,
        REG_ANGLE_STEP,
        REG_PIXELS_PER_METER
    } t_reg_index;

    // register reset values
    localparam logic signed [LSPG_START_W-1:0] LSPG_RST_ANGLE_START = -16'sd12868;
    localparam logic [LSPG_STEP_W-1:0]         LSPG_RST_ANGLE_STEP  = 20'd18301;
    localparam logic [LSPG_SCALE_W-1:0]        LSPG_RST_SCALE       = 16'd5120;

    // angle to phase conversion
    localparam logic signed [33:0] LSPG_QUARTER_TURN = 34'sd1647103;
    localparam logic [25:0]        LSPG_RAD_TO_TURN  = 26'd42722830;
    localparam logic [31:0]        LSPG_EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [30:0]        LSPG_HALF_PI_Q30  = 31'd1686629713;
    localparam logic [30:0]        LSPG_ONE_Q30      = 31'h4000_0000;

    // taylor denominators, sine then cosine
    localparam int unsigned LSPG_DIV_SIN1 = 42;
    localparam int unsigned LSPG_DIV_SIN2 = 20;
    localparam int unsigned LSPG_DIV_SIN3 = 6;
    localparam int unsigned LSPG_DIV_COS1 = 56;
    localparam int unsigned LSPG_DIV_COS2 = 30;
    localparam int unsigned LSPG_DIV_COS3 = 12;

    // reciprocal multipliers, exact for dividends below 2^LSPG_DIV_BITS
    localparam int unsigned LSPG_DIV_BITS = 31;
    localparam int unsigned LSPG_SHF_SIN1 = LSPG_DIV_BITS + $clog2(LSPG_DIV_SIN1);
    localparam int unsigned LSPG_SHF_SIN2 = LSPG_DIV_BITS + $clog2(LSPG_DIV_SIN2);
    localparam int unsigned LSPG_SHF_SIN3 = LSPG_DIV_BITS + $clog2(LSPG_DIV_SIN3);
    localparam int unsigned LSPG_SHF_COS1 = LSPG_DIV_BITS + $clog2(LSPG_DIV_COS1);
    localparam int unsigned LSPG_SHF_COS2 = LSPG_DIV_BITS + $clog2(LSPG_DIV_COS2);
    localparam int unsigned LSPG_SHF_COS3 = LSPG_DIV_BITS + $clog2(LSPG_DIV_COS3);
    localparam logic [31:0] LSPG_RCP_SIN1 = 32'(((64'd1 << LSPG_SHF_SIN1)
        + 64'(LSPG_DIV_SIN1) - 64'd1) / 64'(LSPG_DIV_SIN1));
    localparam logic [31:0] LSPG_RCP_SIN2 = 32'(((64'd1 << LSPG_SHF_SIN2)
        + 64'(LSPG_DIV_SIN2) - 64'd1) / 64'(LSPG_DIV_SIN2));
    localparam logic [31:0] LSPG_RCP_SIN3 = 32'(((64'd1 << LSPG_SHF_SIN3)
        + 64'(LSPG_DIV_SIN3) - 64'd1) / 64'(LSPG_DIV_SIN3));
    localparam logic [31:0] LSPG_RCP_COS1 = 32'(((64'd1 << LSPG_SHF_COS1)
        + 64'(LSPG_DIV_COS1) - 64'd1) / 64'(LSPG_DIV_COS1));
    localparam logic [31:0] LSPG_RCP_COS2 = 32'(((64'd1 << LSPG_SHF_COS2)
        + 64'(LSPG_DIV_COS2) - 64'd1) / 64'(LSPG_DIV_COS2));
    localparam logic [31:0] LSPG_RCP_COS3 = 32'(((64'd1 << LSPG_SHF_COS3)
        + 64'(LSPG_DIV_COS3) - 64'd1) / 64'(LSPG_DIV_COS3));

    // queue between front and back
    localparam int unsigned LSPG_QUEUE_DEPTH = 4;

    // one classified item on its way to the back end
    typedef struct packed {
        logic [LSPG_RANGE_W-1:0] range_reading;
        logic                    eligible;
        logic [1:0]              quad;
        logic signed [30:0]      x;
    } t_work;

    // floor(num / d) as a multiply by the reciprocal and a shift
    function automatic logic [30:0] lspg_div_const(input logic [30:0] num,
                                                   input logic [31:0] rcp,
                                                   input int unsigned shf);
        logic [62:0] prod;
        prod = {32'd0, num} * {31'd0, rcp};
        return 31'(prod >> shf);
    endfunction

    // product of two non-negative q30 values, floored to q30
    function automatic logic [30:0] lspg_mul_q30(input logic [30:0] a,
                                                 input logic [30:0] b);
        logic [61:0] prod;
        prod = {31'd0, a} * {31'd0, b};
        return prod[60:30];
    endfunction

endpackage

>>> rtl/lidar_scan_to_pixel_grid_unit.sv
// lidar sample to pixel grid: each item is one range reading with its beam index and a
// finite flag; the unit forms the beam angle (start + index * step + a quarter turn),
// rotates the range into x and y with a fixed-point sine and cosine, scales by pixels per
// metre, moves the origin to the image centre with y pointing up and truncates toward
// zero, and returns the column, the row and whether the hit lies inside the square image.
// non-finite readings, beams past the scan length and hits outside the image come back
// with plotted low and both coordinates zero. one item is taken and one result given per
// clock when the output side keeps up; an item passes from acceptance to its result
// through five front stages (angle, phase and quadrant reduction), the four-entry queue
// and ten back stages (seven for the horner sine and cosine, then the rotation, the scale
// multiply and the final add and bounds check). every multiplier
// stage is followed by a register. the three registers are written through a plain
// write port and should only be changed while no item is in flight.
module lidar_scan_to_pixel_grid_unit
    import lspg_pkg::*;
#(
    parameter int unsigned IMAGE_SIDE = LSPG_IMAGE_SIDE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [LSPG_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LSPG_CFG_DATA_W-1:0] i_cfg_data,

    // input items
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [LSPG_RANGE_W-1:0]    i_range_reading,
    input  logic [LSPG_BEAM_W-1:0]     i_beam_index,
    input  logic                       i_reading_ok,

    // result items
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [LSPG_PIXEL_W-1:0]    o_pixel_col,
    output logic [LSPG_PIXEL_W-1:0]    o_pixel_row,
    output logic                       o_plotted
);

    // configuration registers
    logic signed [LSPG_START_W-1:0] r_angle_start;
    logic [LSPG_STEP_W-1:0]         r_angle_step;
    logic [LSPG_SCALE_W-1:0]        r_pixels_per_meter;

    // front to queue to back
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_work w_work_in;
    t_work w_work_out;

    // register decode, an index past the map is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start      <= LSPG_RST_ANGLE_START;
            r_angle_step       <= LSPG_RST_ANGLE_STEP;
            r_pixels_per_meter <= LSPG_RST_SCALE;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_ANGLE_START: begin
                    r_angle_start <= i_cfg_data[LSPG_START_W-1:0];
                end
                REG_ANGLE_STEP: begin
                    r_angle_step <= i_cfg_data[LSPG_STEP_W-1:0];
                end
                REG_PIXELS_PER_METER: begin
                    r_pixels_per_meter <= i_cfg_data[LSPG_SCALE_W-1:0];
                end
                default: begin
                    r_angle_start <= r_angle_start;
                end
            endcase
        end
    end

    // front: classifies the sample and reduces its angle to a quadrant and a small angle
    lspg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_range_reading (i_range_reading),
        .i_beam_index    (i_beam_index),
        .i_reading_ok    (i_reading_ok),
        .i_angle_start   (r_angle_start),
        .i_angle_step    (r_angle_step),
        .o_push          (w_push),
        .o_work          (w_work_in),
        .i_full          (w_full)
    );

    // short queue so that each side can stall on its own
    lspg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_work_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_work  (w_work_out),
        .o_empty (w_empty)
    );

    // back: sine and cosine, rotation, scaling and the image bounds check
    lspg_back #(
        .IMAGE_SIDE (IMAGE_SIDE)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (w_empty),
        .o_pop              (w_pop),
        .i_work             (w_work_out),
        .i_pixels_per_meter (r_pixels_per_meter),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_pixel_col        (o_pixel_col),
        .o_pixel_row        (o_pixel_row),
        .o_plotted          (o_plotted)
    );

endmodule

>>> rtl/lspg_front.sv
module lspg_front
    import lspg_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [LSPG_RANGE_W-1:0]        i_range_reading,
    input  logic [LSPG_BEAM_W-1:0]         i_beam_index,
    input  logic                           i_reading_ok,
    input  logic signed [LSPG_START_W-1:0] i_angle_start,
    input  logic [LSPG_STEP_W-1:0]         i_angle_step,
    output logic                           o_push,
    output t_work                          o_work,
    input  logic                           i_full
);

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    // stage payloads
    logic [31:0]             r1_prod;
    logic [LSPG_RANGE_W-1:0] r1_range, r2_range, r3_range, r4_range;
    logic                    r1_elig, r2_elig, r3_elig, r4_elig;
    logic signed [33:0]      r2_angle;
    logic [31:0]             r3_phase;
    logic [1:0]              r4_quad;
    logic signed [29:0]      r4_r;
    t_work                   r5_work;

    logic [31:0]        w_prod;
    logic signed [33:0] w_angle;
    logic signed [60:0] w_turn;
    logic [31:0]        w_rnd;
    logic [31:0]        w_rem;
    logic signed [61:0] w_x;

    assign w_en    = !r_vld[STAGES-1] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_vld[STAGES-1] && !i_full;
    assign o_work  = r5_work;

    // beam angle, phase in turns, quadrant split, reduced angle
    assign w_prod  = {20'd0, i_beam_index} * {12'd0, i_angle_step};
    assign w_angle = $signed({{10{i_angle_start[LSPG_START_W-1]}}, i_angle_start, 8'd0})
                   + $signed({2'b00, r1_prod}) + LSPG_QUARTER_TURN;
    assign w_turn  = r2_angle * $signed({1'b0, LSPG_RAD_TO_TURN});
    assign w_rnd   = r3_phase + LSPG_EIGHTH_TURN;
    assign w_rem   = r3_phase - {w_rnd[31:30], 30'd0};
    assign w_x     = r4_r * $signed({1'b0, LSPG_HALF_PI_Q30});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod  <= w_prod;
            r1_range <= i_range_reading;
            r1_elig  <= i_reading_ok && (32'(i_beam_index) < LSPG_MAX_BEAMS);

            r2_angle <= w_angle;
            r2_range <= r1_range;
            r2_elig  <= r1_elig;

            r3_phase <= w_turn[47:16];
            r3_range <= r2_range;
            r3_elig  <= r2_elig;

            r4_quad  <= w_rnd[31:30];
            r4_r     <= w_rem[29:0];
            r4_range <= r3_range;
            r4_elig  <= r3_elig;

            r5_work.range_reading <= r4_range;
            r5_work.eligible      <= r4_elig;
            r5_work.quad          <= r4_quad;
            r5_work.x             <= w_x[60:30];
        end
    end

endmodule

>>> rtl/lspg_queue.sv
module lspg_queue
    import lspg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_work,
    output logic  o_empty
);

    localparam int unsigned DEPTH = LSPG_QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_work            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_work;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a push");
`endif

endmodule

>>> rtl/lspg_back.sv
module lspg_back
    import lspg_pkg::*;
#(
    parameter int unsigned IMAGE_SIDE = LSPG_IMAGE_SIDE
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    output logic                    o_pop,
    input  t_work                   i_work,
    input  logic [LSPG_SCALE_W-1:0] i_pixels_per_meter,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [LSPG_PIXEL_W-1:0] o_pixel_col,
    output logic [LSPG_PIXEL_W-1:0] o_pixel_row,
    output logic                    o_plotted
);

    localparam int unsigned STAGES = 10;
    localparam logic signed [63:0] CENTER_Q48 = 64'(IMAGE_SIDE / 2) << 48;
    localparam logic [15:0] SIDE = 16'(IMAGE_SIDE);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [STAGES-1:0] r_vld;
    logic              w_en;

    // carried operands
    logic signed [30:0] r1_x, r2_x, r3_x, r4_x, r5_x, r6_x;
    logic [30:0]        r1_x2, r2_x2, r3_x2, r4_x2, r5_x2, r6_x2;
    logic [31:0]        r1_mag, r2_mag, r3_mag, r4_mag, r5_mag, r6_mag, r7_mag, r8_mag;
    logic [1:0]         r1_quad, r2_quad, r3_quad, r4_quad, r5_quad, r6_quad, r7_quad;
    logic               r1_elig, r2_elig, r3_elig, r4_elig, r5_elig, r6_elig, r7_elig;
    logic               r8_elig, r9_elig;

    // horner terms, sine and cosine side by side
    logic [30:0]        r2_ds, r2_dc, r3_ps, r3_pc, r4_ds, r4_dc;
    logic [30:0]        r5_ps, r5_pc, r6_ds, r6_dc, r7_pc;
    logic signed [31:0] r7_sin;
    logic signed [31:0] r8_cs, r8_sn;
    logic signed [63:0] r9_px, r9_py;

    logic [LSPG_PIXEL_W-1:0] r_col, r_row;
    logic                    r_plot;

    logic signed [61:0] w_xx;
    logic [31:0]        w_mag;
    logic signed [62:0] w_sin;
    logic signed [31:0] w_cos, w_sin_q;
    logic signed [31:0] w_cs, w_sn;
    logic signed [64:0] w_px, w_py;
    logic signed [63:0] w_sum_x, w_sum_y;
    logic [15:0]        w_hi_x, w_hi_y;
    logic               w_near_x, w_near_y, w_ok_x, w_ok_y;

    assign w_en    = !r_vld[STAGES-1] || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_vld[STAGES-1];

    assign o_pixel_col = r_col;
    assign o_pixel_row = r_row;
    assign o_plotted   = r_plot;

    assign w_xx  = i_work.x * i_work.x;
    assign w_mag = {16'd0, i_work.range_reading} * {16'd0, i_pixels_per_meter};
    assign w_sin = r6_x * $signed({1'b0, LSPG_ONE_Q30 - r6_ds});

    assign w_cos   = $signed({1'b0, LSPG_ONE_Q30}) - $signed({2'b00, r7_pc[30:1]});
    assign w_sin_q = r7_sin;

    // quadrant rotation of (cos, sin)
    always_comb begin
        case (r7_quad)
            QUAD_0: begin
                w_cs = w_cos;
                w_sn = w_sin_q;
            end
            QUAD_1: begin
                w_cs = -w_sin_q;
                w_sn = w_cos;
            end
            QUAD_2: begin
                w_cs = -w_cos;
                w_sn = -w_sin_q;
            end
            default: begin
                w_cs = w_sin_q;
                w_sn = -w_cos;
            end
        endcase
    end

    assign w_px = $signed({1'b0, r8_mag}) * r8_cs;
    assign w_py = $signed({1'b0, r8_mag}) * r8_sn;

    // truncation toward zero: a sum in (-1, 0) still lands on pixel 0
    assign w_sum_x  = CENTER_Q48 + r9_px;
    assign w_sum_y  = CENTER_Q48 - r9_py;
    assign w_hi_x   = w_sum_x[63:48];
    assign w_hi_y   = w_sum_y[63:48];
    assign w_near_x = (w_hi_x == '1) && (w_sum_x[47:0] != '0);
    assign w_near_y = (w_hi_y == '1) && (w_sum_y[47:0] != '0);
    assign w_ok_x   = (!w_hi_x[15] && (w_hi_x < SIDE)) || w_near_x;
    assign w_ok_y   = (!w_hi_y[15] && (w_hi_y < SIDE)) || w_near_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x    <= i_work.x;
            r1_x2   <= w_xx[60:30];
            r1_mag  <= w_mag;
            r1_quad <= i_work.quad;
            r1_elig <= i_work.eligible;

            r2_ds   <= lspg_div_const(r1_x2, LSPG_RCP_SIN1, LSPG_SHF_SIN1);
            r2_dc   <= lspg_div_const(r1_x2, LSPG_RCP_COS1, LSPG_SHF_COS1);
            r2_x    <= r1_x;
            r2_x2   <= r1_x2;
            r2_mag  <= r1_mag;
            r2_quad <= r1_quad;
            r2_elig <= r1_elig;

            r3_ps   <= lspg_mul_q30(r2_x2, LSPG_ONE_Q30 - r2_ds);
            r3_pc   <= lspg_mul_q30(r2_x2, LSPG_ONE_Q30 - r2_dc);
            r3_x    <= r2_x;
            r3_x2   <= r2_x2;
            r3_mag  <= r2_mag;
            r3_quad <= r2_quad;
            r3_elig <= r2_elig;

            r4_ds   <= lspg_div_const(r3_ps, LSPG_RCP_SIN2, LSPG_SHF_SIN2);
            r4_dc   <= lspg_div_const(r3_pc, LSPG_RCP_COS2, LSPG_SHF_COS2);
            r4_x    <= r3_x;
            r4_x2   <= r3_x2;
            r4_mag  <= r3_mag;
            r4_quad <= r3_quad;
            r4_elig <= r3_elig;

            r5_ps   <= lspg_mul_q30(r4_x2, LSPG_ONE_Q30 - r4_ds);
            r5_pc   <= lspg_mul_q30(r4_x2, LSPG_ONE_Q30 - r4_dc);
            r5_x    <= r4_x;
            r5_x2   <= r4_x2;
            r5_mag  <= r4_mag;
            r5_quad <= r4_quad;
            r5_elig <= r4_elig;

            r6_ds   <= lspg_div_const(r5_ps, LSPG_RCP_SIN3, LSPG_SHF_SIN3);
            r6_dc   <= lspg_div_const(r5_pc, LSPG_RCP_COS3, LSPG_SHF_COS3);
            r6_x    <= r5_x;
            r6_x2   <= r5_x2;
            r6_mag  <= r5_mag;
            r6_quad <= r5_quad;
            r6_elig <= r5_elig;

            r7_sin  <= w_sin[61:30];
            r7_pc   <= lspg_mul_q30(r6_x2, LSPG_ONE_Q30 - r6_dc);
            r7_mag  <= r6_mag;
            r7_quad <= r6_quad;
            r7_elig <= r6_elig;

            r8_cs   <= w_cs;
            r8_sn   <= w_sn;
            r8_mag  <= r7_mag;
            r8_elig <= r7_elig;

            r9_px   <= w_px[63:0];
            r9_py   <= w_py[63:0];
            r9_elig <= r8_elig;

            r_plot  <= r9_elig && w_ok_x && w_ok_y;
            r_col   <= (r9_elig && w_ok_x && w_ok_y && !w_near_x)
                       ? w_hi_x[LSPG_PIXEL_W-1:0] : '0;
            r_row   <= (r9_elig && w_ok_x && w_ok_y && !w_near_y)
                       ? w_hi_y[LSPG_PIXEL_W-1:0] : '0;
        end
    end

endmodule
